/* rtl/csrp_pkg.sv */
// ----------------------------------------------------------------------------
// csrp_pkg
// Widths, constants and pipeline types shared by the register planner files.
// ----------------------------------------------------------------------------
package csrp_pkg;

	localparam int CLK_W  = 2;
	localparam int FREQ_W = 28;
	localparam int XTAL_W = 26;
	localparam int DIV_W  = 11;
	localparam int MULT_W = 7;
	localparam int NUM_W  = 19;
	localparam int VCO_W  = 31;
	localparam int TGT_W  = 30;
	localparam int P1_W   = 18;
	localparam int P2_W   = 20;
	localparam int P3_W   = 20;
	localparam int CNT_W  = 5;

	localparam logic [TGT_W-1:0]  VCO_TARGET = TGT_W'(650000000);
	localparam logic [FREQ_W-1:0] FREQ_MIN   = FREQ_W'(320000);
	localparam logic [FREQ_W-1:0] FREQ_MAX   = FREQ_W'(225000000);
	localparam logic [XTAL_W-1:0] XTAL_MIN   = XTAL_W'(10000000);
	localparam logic [XTAL_W-1:0] XTAL_MAX   = XTAL_W'(40000000);
	localparam logic [XTAL_W-1:0] XTAL_RESET = XTAL_W'(25000000);

	localparam logic [CLK_W-1:0] CLK_OUT0 = 2'd0;
	localparam logic [CLK_W-1:0] CLK_OUT1 = 2'd1;

	localparam logic [7:0] PLL_A_BASE = 8'd26;
	localparam logic [7:0] PLL_B_BASE = 8'd34;
	localparam logic [7:0] MS0_BASE   = 8'd42;
	localparam logic [7:0] MS1_BASE   = 8'd50;
	localparam logic [7:0] MS2_BASE   = 8'd58;
	localparam logic [7:0] CTL0_ADDR  = 8'd16;
	localparam logic [7:0] CTL1_ADDR  = 8'd17;
	localparam logic [7:0] CTL2_ADDR  = 8'd18;

	localparam logic [7:0] CTL_INT_MODE  = 8'h40;
	localparam logic [7:0] CTL_SRC_MS    = 8'h0C;
	localparam logic [7:0] CTL_PLL_B     = 8'h20;
	localparam logic [7:0] CTL_DRIVE_8MA = 8'h03;
	localparam logic [7:0] MS_DIVBY4     = 8'h0C;

	localparam logic [P3_W-1:0] FRAC_DENOM = P3_W'(20'h80000);
	localparam logic [P1_W-1:0] P1_OFFSET  = P1_W'(512);

	localparam logic [CNT_W-1:0] LAST_WRITE = CNT_W'(16);

	typedef struct packed {
		logic [CLK_W-1:0]  clk;
		logic [FREQ_W-1:0] f;
		logic [XTAL_W-1:0] xt;
		logic [TGT_W-1:0]  r;
		logic [DIV_W-1:0]  q;
	} csrp_a_t;

	typedef struct packed {
		logic [CLK_W-1:0]  clk;
		logic [XTAL_W-1:0] xt;
		logic [DIV_W-1:0]  div;
		logic [VCO_W-1:0]  r;
		logic [MULT_W-1:0] q;
	} csrp_b_t;

	typedef struct packed {
		logic [CLK_W-1:0]  clk;
		logic [XTAL_W-1:0] xt;
		logic [DIV_W-1:0]  div;
		logic [MULT_W-1:0] mult;
		logic [XTAL_W-1:0] r;
		logic [NUM_W-1:0]  q;
	} csrp_c_t;

	typedef struct packed {
		logic [CLK_W-1:0]  clk;
		logic [DIV_W-1:0]  div;
		logic [MULT_W-1:0] mult;
		logic [NUM_W-1:0]  num;
	} csrp_plan_t;

endpackage

/* rtl/csrp_if.sv */
// ----------------------------------------------------------------------------
// csrp_if
// Valid/ready channels for requests and register writes.
// ----------------------------------------------------------------------------
interface csrp_req_if;
	import csrp_pkg::*;
	logic              valid;
	logic              ready;
	logic [CLK_W-1:0]  clock_index;
	logic [FREQ_W-1:0] out_frequency;
	modport source(output valid, clock_index, out_frequency, input ready);
	modport sink(input valid, clock_index, out_frequency, output ready);
endinterface

interface csrp_wr_if;
	logic       valid;
	logic       ready;
	logic [7:0] reg_address;
	logic [7:0] reg_value;
	logic       final_write;
	modport source(output valid, reg_address, reg_value, final_write, input ready);
	modport sink(input valid, reg_address, reg_value, final_write, output ready);
endinterface

/* rtl/clock_synth_register_planner_top.sv */
// ----------------------------------------------------------------------------
// clock_synth_register_planner_top
// Turns an output-clock frequency request into seventeen synthesizer writes.
// ----------------------------------------------------------------------------
// A request (clock index, frequency in Hz) enters a 41-stage pipeline that
// clamps the inputs, finds the smallest even output divider with
// divider * f >= 650 MHz, forms the VCO frequency, and divides it by the
// crystal into a 7-bit multiplier and a 19-bit fraction, one quotient bit per
// stage. The pipeline takes a request in every cycle while its last stage is
// free. Each request then streams 17 writes (8 PLL, 8 multisynth, the
// clock-control byte flagged by final_write) through a single output
// register, so the sustained request rate is set by that one write port.
// Up to 41 further requests queue in the pipeline meanwhile.
// The crystal register (reset 25 MHz) is written through xtal_we/xtal_data
// and must only change while no request is in flight.
module clock_synth_register_planner_top (
	input  logic                        clk,
	input  logic                        arst_n,
	csrp_req_if.sink                    req,
	csrp_wr_if.source                   wr,
	input  logic                        xtal_we,
	input  logic [csrp_pkg::XTAL_W-1:0] xtal_data
);
	import csrp_pkg::*;

	logic [XTAL_W-1:0] xtal_q;
	logic              pipe_en;
	logic              plan_valid;
	logic              plan_ready;
	csrp_plan_t        plan;

	// hold the crystal setting; clamping happens at pipeline entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtal_q <= XTAL_RESET;
		end else if (xtal_we) begin
			xtal_q <= xtal_data;
		end
	end

	// advance the whole pipeline unless its last plan waits on the serializer
	assign pipe_en   = !plan_valid || plan_ready;
	assign req.ready = pipe_en;

	csrp_divpipe u_divpipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (req.valid),
		.in_clk    (req.clock_index),
		.in_f      (req.out_frequency),
		.in_xt     (xtal_q),
		.out_valid (plan_valid),
		.out_plan  (plan)
	);

	// pack and stream the writes; a transfer out needs wr.ready
	csrp_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (plan_valid),
		.in_ready (plan_ready),
		.in_plan  (plan),
		.wr       (wr)
	);

endmodule

/* rtl/csrp_divpipe.sv */
// ----------------------------------------------------------------------------
// csrp_divpipe
// Clamp, output divider, VCO product, multiplier and fractional numerator,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module csrp_divpipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [csrp_pkg::CLK_W-1:0]  in_clk,
	input  logic [csrp_pkg::FREQ_W-1:0] in_f,
	input  logic [csrp_pkg::XTAL_W-1:0] in_xt,
	output logic                        out_valid,
	output csrp_pkg::csrp_plan_t        out_plan
);
	import csrp_pkg::*;

	localparam int A_DW = FREQ_W + DIV_W;
	localparam int B_DW = VCO_W + 2;
	localparam int C_DW = XTAL_W + 2;

	csrp_a_t a_s [DIV_W+1];
	logic    a_v_s [DIV_W+1];
	csrp_b_t b_s [MULT_W+1];
	logic    b_v_s [MULT_W+1];
	csrp_c_t c_s [NUM_W+1];
	logic    c_v_s [NUM_W+1];

	logic [CLK_W-1:0]  rd_clk_s;
	logic [FREQ_W-1:0] rd_f_s;
	logic [XTAL_W-1:0] rd_xt_s;
	logic [DIV_W-1:0]  rd_div_s;
	logic              rd_v_s;

	logic [FREQ_W-1:0] f_cl;
	logic [XTAL_W-1:0] xt_cl;
	logic [DIV_W-1:0]  d_ceil;
	logic [DIV_W-1:0]  d_even;
	logic [A_DW-1:0]   vco_prod;

	// clamp into the legal ranges at entry
	always_comb begin
		f_cl = in_f;
		if (in_f < FREQ_MIN) f_cl = FREQ_MIN;
		if (in_f > FREQ_MAX) f_cl = FREQ_MAX;
		xt_cl = in_xt;
		if (in_xt < XTAL_MIN) xt_cl = XTAL_MIN;
		if (in_xt > XTAL_MAX) xt_cl = XTAL_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) a_v_s[0] <= 1'b0;
		else if (en) a_v_s[0] <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0].clk <= in_clk;
			a_s[0].f   <= f_cl;
			a_s[0].xt  <= xt_cl;
			a_s[0].r   <= VCO_TARGET;
			a_s[0].q   <= '0;
		end
	end

	// output divider: floor(650 MHz / f), remainder kept for the ceiling
	for (genvar j = 1; j <= DIV_W; j++) begin : g_a
		localparam int SH = DIV_W - j;
		logic [A_DW-1:0] diff;
		csrp_a_t         nxt;
		assign diff = A_DW'(a_s[j-1].r) - (A_DW'(a_s[j-1].f) << SH);
		always_comb begin
			nxt = a_s[j-1];
			if (!diff[A_DW-1]) begin
				nxt.r = diff[TGT_W-1:0];
				nxt.q = a_s[j-1].q | (DIV_W'(1) << SH);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) a_v_s[j] <= 1'b0;
			else if (en) a_v_s[j] <= a_v_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) a_s[j] <= nxt;
		end
	end

	// round up, then up to the next even value
	assign d_ceil = a_s[DIV_W].q + DIV_W'(a_s[DIV_W].r != '0);
	assign d_even = d_ceil + DIV_W'(d_ceil[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_v_s <= 1'b0;
		else if (en) rd_v_s <= a_v_s[DIV_W];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rd_clk_s <= a_s[DIV_W].clk;
			rd_f_s   <= a_s[DIV_W].f;
			rd_xt_s  <= a_s[DIV_W].xt;
			rd_div_s <= d_even;
		end
	end

	assign vco_prod = A_DW'(rd_f_s) * A_DW'(rd_div_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) b_v_s[0] <= 1'b0;
		else if (en) b_v_s[0] <= rd_v_s;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b_s[0].clk <= rd_clk_s;
			b_s[0].xt  <= rd_xt_s;
			b_s[0].div <= rd_div_s;
			b_s[0].r   <= vco_prod[VCO_W-1:0];
			b_s[0].q   <= '0;
		end
	end

	// PLL multiplier: vco / xtal
	for (genvar j = 1; j <= MULT_W; j++) begin : g_b
		localparam int SH = MULT_W - j;
		logic [B_DW-1:0] diff;
		csrp_b_t         nxt;
		assign diff = B_DW'(b_s[j-1].r) - (B_DW'(b_s[j-1].xt) << SH);
		always_comb begin
			nxt = b_s[j-1];
			if (!diff[B_DW-1]) begin
				nxt.r = diff[VCO_W-1:0];
				nxt.q = b_s[j-1].q | (MULT_W'(1) << SH);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) b_v_s[j] <= 1'b0;
			else if (en) b_v_s[j] <= b_v_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) b_s[j] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_v_s[0] <= 1'b0;
		else if (en) c_v_s[0] <= b_v_s[MULT_W];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s[0].clk  <= b_s[MULT_W].clk;
			c_s[0].xt   <= b_s[MULT_W].xt;
			c_s[0].div  <= b_s[MULT_W].div;
			c_s[0].mult <= b_s[MULT_W].q;
			c_s[0].r    <= b_s[MULT_W].r[XTAL_W-1:0];
			c_s[0].q    <= '0;
		end
	end

	// fractional numerator: remainder * 2^19 / xtal
	for (genvar j = 1; j <= NUM_W; j++) begin : g_c
		logic [XTAL_W:0]   rs;
		logic [C_DW-1:0]   diff;
		csrp_c_t           nxt;
		assign rs   = {c_s[j-1].r, 1'b0};
		assign diff = C_DW'(rs) - C_DW'(c_s[j-1].xt);
		always_comb begin
			nxt   = c_s[j-1];
			nxt.r = diff[C_DW-1] ? rs[XTAL_W-1:0] : diff[XTAL_W-1:0];
			nxt.q = {c_s[j-1].q[NUM_W-2:0], ~diff[C_DW-1]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) c_v_s[j] <= 1'b0;
			else if (en) c_v_s[j] <= c_v_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) c_s[j] <= nxt;
		end
	end

	assign out_valid     = c_v_s[NUM_W];
	assign out_plan.clk  = c_s[NUM_W].clk;
	assign out_plan.div  = c_s[NUM_W].div;
	assign out_plan.mult = c_s[NUM_W].mult;
	assign out_plan.num  = c_s[NUM_W].q;

endmodule

/* rtl/csrp_serializer.sv */
// ----------------------------------------------------------------------------
// csrp_serializer
// Pack one plan into P1/P2/P3 values and stream its seventeen writes.
// ----------------------------------------------------------------------------
module csrp_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  csrp_pkg::csrp_plan_t in_plan,
	csrp_wr_if.source            wr
);
	import csrp_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CLK_W-1:0]  clk_q;
	logic [P1_W-1:0]   pll_p1_q;
	logic [P2_W-1:0]   pll_p2_q;
	logic [P3_W-1:0]   pll_p3_q;
	logic [P1_W-1:0]   ms_p1_q;
	logic [7:0]        ms_extra_q;

	logic              out_v_q;
	logic [7:0]        out_addr_q;
	logic [7:0]        out_val_q;
	logic              out_final_q;

	logic              take;
	logic              load;
	logic [7:0]        pll_byte;
	logic [7:0]        ms_byte;
	logic [7:0]        pll_base;
	logic [7:0]        ms_base;
	logic [7:0]        ctl_addr;
	logic [7:0]        ctl_val;
	logic [7:0]        nxt_addr;
	logic [7:0]        nxt_val;

	function automatic logic [7:0] param_byte(input logic [2:0] k, input logic [P1_W-1:0] p1,
			input logic [P2_W-1:0] p2, input logic [P3_W-1:0] p3, input logic [7:0] extra);
		logic [7:0] b;
		case (k)
			3'd0:    b = p3[15:8];
			3'd1:    b = p3[7:0];
			3'd2:    b = {6'b0, p1[17:16]} | extra;
			3'd3:    b = p1[15:8];
			3'd4:    b = p1[7:0];
			3'd5:    b = {p3[19:16], p2[19:16]};
			3'd6:    b = p2[15:8];
			default: b = p2[7:0];
		endcase
		return b;
	endfunction

	assign take     = !out_v_q || wr.ready;
	assign in_ready = !busy_q || (take && cnt_q == LAST_WRITE);
	assign load     = in_valid && in_ready;

	always_comb begin
		pll_base = (clk_q == CLK_OUT1) ? PLL_B_BASE : PLL_A_BASE;
		case (clk_q)
			CLK_OUT0: begin ms_base = MS0_BASE; ctl_addr = CTL0_ADDR; end
			CLK_OUT1: begin ms_base = MS1_BASE; ctl_addr = CTL1_ADDR; end
			default:  begin ms_base = MS2_BASE; ctl_addr = CTL2_ADDR; end
		endcase
		ctl_val = CTL_DRIVE_8MA | CTL_SRC_MS | CTL_INT_MODE;
		if (clk_q == CLK_OUT1) ctl_val = ctl_val | CTL_PLL_B;
		pll_byte = param_byte(cnt_q[2:0], pll_p1_q, pll_p2_q, pll_p3_q, 8'h00);
		ms_byte  = param_byte(cnt_q[2:0], ms_p1_q, '0, P3_W'(1), ms_extra_q);
		if (cnt_q == LAST_WRITE) begin
			nxt_addr = ctl_addr;
			nxt_val  = ctl_val;
		end else if (!cnt_q[3]) begin
			nxt_addr = pll_base + {5'b0, cnt_q[2:0]};
			nxt_val  = pll_byte;
		end else begin
			nxt_addr = ms_base + {5'b0, cnt_q[2:0]};
			nxt_val  = ms_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (take) out_v_q <= busy_q;
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (take && busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_WRITE) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && busy_q) begin
			out_addr_q  <= nxt_addr;
			out_val_q   <= nxt_val;
			out_final_q <= (cnt_q == LAST_WRITE);
		end
		if (load) begin
			clk_q    <= in_plan.clk;
			pll_p1_q <= (P1_W'(in_plan.mult) << 7) + P1_W'(in_plan.num[NUM_W-1:12]) - P1_OFFSET;
			pll_p2_q <= {1'b0, in_plan.num[11:0], 7'b0};
			pll_p3_q <= (in_plan.num == '0) ? P3_W'(1) : FRAC_DENOM;
			if (in_plan.div == DIV_W'(4)) begin
				ms_p1_q    <= '0;
				ms_extra_q <= MS_DIVBY4;
			end else begin
				ms_p1_q    <= (P1_W'(in_plan.div) << 7) - P1_OFFSET;
				ms_extra_q <= 8'h00;
			end
		end
	end

	assign wr.valid       = out_v_q;
	assign wr.reg_address = out_addr_q;
	assign wr.reg_value   = out_val_q;
	assign wr.final_write = out_final_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= LAST_WRITE)
		else $error("write counter past the control byte");

	a_final_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_final_q) |->
		(out_addr_q == CTL0_ADDR || out_addr_q == CTL1_ADDR || out_addr_q == CTL2_ADDR))
		else $error("final write not at a clock-control address");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(load && busy_q) |-> (take && cnt_q == LAST_WRITE))
		else $error("plan loaded over an unfinished run");

endmodule

/* tb/tb_clock_synth_register_planner_top.sv */
// ----------------------------------------------------------------------------
// tb_clock_synth_register_planner_top
// Checks the seventeen register writes planned for each clock request against
// a behavioral planner, across several crystal settings and random pacing.
// ----------------------------------------------------------------------------
module tb_clock_synth_register_planner_top;
	timeunit 1ns;
	timeprecision 1ps;
	import csrp_pkg::*;

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] value;
		logic       last;
	} reg_write_t;

	logic clk;
	logic arst_n;
	logic xtal_we;
	logic [XTAL_W-1:0] xtal_data;

	csrp_req_if req();
	csrp_wr_if  wr();

	clock_synth_register_planner_top dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .wr(wr.source),
		.xtal_we(xtal_we), .xtal_data(xtal_data)
	);

	// planner's own copy of the crystal register
	logic [XTAL_W-1:0] xtal_reg;
	reg_write_t planned_writes[$];
	int errors;
	int stall_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Limit: slowest run is roughly 250 requests x (17 writes x long stalls + gaps).
	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (time %0t)", what, got, want, $realtime);
	endtask

	task automatic push_params(input logic [7:0] base, input longint unsigned p1,
			input longint unsigned p2, input longint unsigned p3, input logic [7:0] extra);
		planned_writes.push_back('{base + 8'd0, 8'(p3 >> 8), 1'b0});
		planned_writes.push_back('{base + 8'd1, 8'(p3), 1'b0});
		planned_writes.push_back('{base + 8'd2, 8'((p1 >> 16) & 3) | extra, 1'b0});
		planned_writes.push_back('{base + 8'd3, 8'(p1 >> 8), 1'b0});
		planned_writes.push_back('{base + 8'd4, 8'(p1), 1'b0});
		planned_writes.push_back('{base + 8'd5,
			8'((((p3 >> 16) & 4'hF) << 4) | ((p2 >> 16) & 4'hF)), 1'b0});
		planned_writes.push_back('{base + 8'd6, 8'(p2 >> 8), 1'b0});
		planned_writes.push_back('{base + 8'd7, 8'(p2), 1'b0});
	endtask

	// Work out the full write sequence for one request.
	task automatic plan_request(input logic [CLK_W-1:0] ci, input logic [FREQ_W-1:0] fin);
		longint unsigned f, xt, dv, vco, mult, num, p1, p2, p3;
		logic [7:0] pll_base, ms_base, ctl_addr, ctl;
		f = fin;
		xt = xtal_reg;
		if (f < 320000) f = 320000;
		if (f > 225000000) f = 225000000;
		if (xt < 10000000) xt = 10000000;
		if (xt > 40000000) xt = 40000000;
		dv = (650000000 + f - 1) / f;
		if (dv[0]) dv++;
		vco = f * dv;
		mult = vco / xt;
		num = ((vco % xt) * 64'h80000) / xt;
		pll_base = (ci == CLK_OUT1) ? PLL_B_BASE : PLL_A_BASE;
		if (ci == CLK_OUT0) begin
			ms_base = MS0_BASE; ctl_addr = CTL0_ADDR;
		end else if (ci == CLK_OUT1) begin
			ms_base = MS1_BASE; ctl_addr = CTL1_ADDR;
		end else begin
			ms_base = MS2_BASE; ctl_addr = CTL2_ADDR;
		end
		if (num == 0) begin
			p1 = 128 * mult - 512; p2 = 0; p3 = 1;
		end else begin
			p1 = 128 * mult + (num >> 12) - 512;
			p2 = 128 * (num & 12'hFFF);
			p3 = 64'h80000;
		end
		push_params(pll_base, p1, p2, p3, 8'h00);
		if (dv == 4) push_params(ms_base, 0, 0, 1, MS_DIVBY4);
		else push_params(ms_base, 128 * dv - 512, 0, 1, 8'h00);
		ctl = CTL_DRIVE_8MA | CTL_SRC_MS | CTL_INT_MODE;
		if (ci == CLK_OUT1) ctl |= CTL_PLL_B;
		planned_writes.push_back('{ctl_addr, ctl, 1'b1});
	endtask

	// Send one request; hold valid until the transfer, leave it up for a follow-on.
	task automatic send_request(input logic [CLK_W-1:0] ci, input logic [FREQ_W-1:0] f);
		req.valid <= 1'b1;
		req.clock_index <= ci;
		req.out_frequency <= f;
		do @(posedge clk); while (!req.ready);
		plan_request(ci, f);
		@(negedge clk);
	endtask

	// Drop valid, then wait for the next falling clock edge.
	task automatic idle_req();
		req.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Random idle cycles between bursts.
	task automatic sender_gap();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
		if (n > 0) begin
			idle_req();
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		idle_req();
		while (planned_writes.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_xtal(input logic [XTAL_W-1:0] v);
		xtal_we <= 1'b1;
		xtal_data <= v;
		@(negedge clk);
		xtal_we <= 1'b0;
		xtal_reg = v;
	endtask

	// Check each write transfer against the oldest planned write.
	always @(posedge clk) begin
		reg_write_t exp_w;
		if (arst_n && wr.valid && wr.ready) begin
			if (planned_writes.size() == 0) begin
				report_mismatch("unexpected write addr", wr.reg_address, -1);
			end else begin
				exp_w = planned_writes.pop_front();
				if (wr.reg_address !== exp_w.addr)
					report_mismatch("reg_address", wr.reg_address, exp_w.addr);
				if (wr.reg_value !== exp_w.value)
					report_mismatch("reg_value", wr.reg_value, exp_w.value);
				if (wr.final_write !== exp_w.last)
					report_mismatch("final_write", wr.final_write, exp_w.last);
			end
		end
	end

	// Receiver stall pattern; mode 0 never stalls.
	always @(negedge clk) begin
		case (stall_mode)
			0: wr.ready <= 1'b1;
			1: wr.ready <= ($urandom_range(0, 3) != 0);
			default: wr.ready <= ($urandom_range(0, 9) > 6);
		endcase
	end

	task automatic test_directed();
		logic [FREQ_W-1:0] freqs[12];
		freqs = '{28'd0, 28'd319999, 28'd320000, 28'd225000000, 28'd225000001,
			28'hFFFFFFF, 28'd162500000, 28'd100000000, 28'd10000000,
			28'd650000, 28'd25000000, 28'd7000000};
		foreach (freqs[i]) send_request(2'(i % 4), freqs[i]);
		// drive every clock index including three, with divide-by-4
		for (int c = 0; c < 4; c++) send_request(2'(c), 28'd162500000);
		send_request(2'd3, 28'h5555555);
		send_request(2'd1, 28'hAAAAAAA);
		wait_drained();
	endtask

	task automatic test_random(input int count);
		int burst;
		logic [FREQ_W-1:0] f;
		bit paused;
		paused = 1'b0;
		while (count > 0) begin
			burst = $urandom_range(1, 8);
			repeat (burst) begin
				case ($urandom_range(0, 7))
					0: f = FREQ_W'($urandom());
					1: f = FREQ_W'($urandom_range(0, 400000));
					2: f = FREQ_W'($urandom_range(150000000, 230000000));
					default: f = FREQ_W'($urandom_range(320000, 225000000));
				endcase
				send_request(2'($urandom_range(0, 3)), f);
				count--;
			end
			sender_gap();
			// pause once so everything drains mid-run
			if (!paused && count <= 20) begin
				paused = 1'b1;
				idle_req();
				while (planned_writes.size() != 0) @(negedge clk);
			end
		end
		wait_drained();
	endtask

	task automatic test_xtal_settings();
		write_xtal(XTAL_W'(10000000));
		stall_mode = 1;
		test_random(30);
		write_xtal(XTAL_W'(40000000));
		stall_mode = 2;
		test_random(30);
		write_xtal(XTAL_W'(27000000));
		test_random(30);
		write_xtal(XTAL_W'(0));
		stall_mode = 0;
		test_random(15);
		write_xtal(XTAL_W'(26'h3FFFFFF));
		test_random(15);
		write_xtal(XTAL_W'($urandom_range(10000000, 40000000)));
		stall_mode = 1;
		test_random(30);
	endtask

	initial begin
		errors = 0;
		stall_mode = 0;
		xtal_reg = XTAL_RESET;
		arst_n = 1'b0;
		xtal_we = 1'b0;
		xtal_data = '0;
		req.valid = 1'b0;
		req.clock_index = '0;
		req.out_frequency = '0;
		wr.ready = 1'b1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		stall_mode = 1;
		test_random(60);
		test_xtal_settings();
		if (errors == 0 && planned_writes.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

/* clock_synth_register_planner_top.f */
rtl/csrp_pkg.sv
rtl/csrp_if.sv
rtl/csrp_divpipe.sv
rtl/csrp_serializer.sv
rtl/clock_synth_register_planner_top.sv
tb/tb_clock_synth_register_planner_top.sv
